// ----- sv/pcmfc_pkg.sv -----
// Shared types, constants and helpers for the PCM format convert / mono downmix block.
// No dependencies; used by pcmfc_lane, pcmfc_div and pcm_format_convert_downmix_mono.
package pcmfc_pkg;

    localparam int NUM_LANES        = 8;
    localparam int MAX_CHANNELS_DEF = 8;
    localparam int WORD_W           = 32;
    localparam int LANE_W           = 61;
    localparam int PAIR_W           = 63;
    localparam int SUM_W            = 64;
    localparam int CNT_W            = 4;
    localparam int CFG_IDX_W        = 1;
    localparam int CFG_DATA_W       = 4;
    localparam int RECIP_W          = 36;
    localparam int RECIP_SHIFT      = 37;
    localparam int SPLIT_W          = 17;

    typedef enum logic [1:0] {
        FMT_U8  = 2'd0,
        FMT_S16 = 2'd1,
        FMT_S32 = 2'd2,
        FMT_F32 = 2'd3
    } sample_fmt_t;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_SAMPLE_FORMAT = 1'b0,
        REG_CHANNEL_COUNT = 1'b1
    } cfg_reg_t;

    localparam sample_fmt_t      FMT_RESET = FMT_S16;
    localparam logic [CNT_W-1:0] CNT_RESET = 4'd2;

    // per-channel float saturation, 2^59
    localparam logic [59:0] CHAN_SAT = 60'd1 << 59;

    // ceil(2^37 / d) for the odd divisors of 2n
    localparam logic [RECIP_W-1:0] RECIP3 = RECIP_W'(((64'd1 << RECIP_SHIFT) / 64'd3) + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP5 = RECIP_W'(((64'd1 << RECIP_SHIFT) / 64'd5) + 64'd1);
    localparam logic [RECIP_W-1:0] RECIP7 = RECIP_W'(((64'd1 << RECIP_SHIFT) / 64'd7) + 64'd1);

    // 2n = 2^shift * odd
    typedef struct packed {
        logic [CNT_W-1:0] cnt;
        logic [2:0]       shift;
        logic [2:0]       odd;
    } div_ctl_t;

    function automatic div_ctl_t div_ctl(input logic [CNT_W-1:0] n);
        div_ctl_t c;
        c.cnt = n;
        case (n)
            4'd2:    begin c.shift = 3'd2; c.odd = 3'd1; end
            4'd3:    begin c.shift = 3'd1; c.odd = 3'd3; end
            4'd4:    begin c.shift = 3'd3; c.odd = 3'd1; end
            4'd5:    begin c.shift = 3'd1; c.odd = 3'd5; end
            4'd6:    begin c.shift = 3'd2; c.odd = 3'd3; end
            4'd7:    begin c.shift = 3'd1; c.odd = 3'd7; end
            4'd8:    begin c.shift = 3'd4; c.odd = 3'd1; end
            default: begin c.shift = 3'd1; c.odd = 3'd1; end
        endcase
        return c;
    endfunction

    function automatic logic [RECIP_W-1:0] recip(input logic [2:0] odd);
        logic [RECIP_W-1:0] r;
        case (odd)
            3'd3:    r = RECIP3;
            3'd5:    r = RECIP5;
            3'd7:    r = RECIP7;
            default: r = '0;
        endcase
        return r;
    endfunction

endpackage

// ----- sv/pcm_format_convert_downmix_mono.sv -----
// Top level of the PCM format convert and mono downmix block.
// Depends on pcmfc_pkg, pcmfc_lane and pcmfc_div.
//
// One multichannel frame is taken per clock (start high while busy is low) and its mono
// average comes out on mono_sample, with done high for that one cycle; the receiver cannot
// stall, so every accepted beat is delivered. The six stages are lane decode, one
// adder-tree level, final sum, divide setup, reciprocal partial products and the final
// quotient/saturation. busy is set by reset and cleared at the first clock edge after it.
// sample_format and channel_count are written through cfg_we/cfg_index/cfg_data and must
// only change while no beat is in flight.
module pcm_format_convert_downmix_mono #(
    parameter int MAX_CHANNELS = pcmfc_pkg::MAX_CHANNELS_DEF
) (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [pcmfc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [pcmfc_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  logic                                 start,
    output logic                                 busy,
    input  logic [31:0]                          chan0_word,
    input  logic [31:0]                          chan1_word,
    input  logic [31:0]                          chan2_word,
    input  logic [31:0]                          chan3_word,
    input  logic [31:0]                          chan4_word,
    input  logic [31:0]                          chan5_word,
    input  logic [31:0]                          chan6_word,
    input  logic [31:0]                          chan7_word,
    input  logic                                 frame_end_in,
    output logic                                 done,
    output logic signed [31:0]                   mono_sample,
    output logic                                 frame_end_out
);

    localparam int NL = pcmfc_pkg::NUM_LANES;

    pcmfc_pkg::sample_fmt_t          fmt_reg;
    logic [pcmfc_pkg::CNT_W-1:0]     cnt_reg;
    logic                            busy_reg;

    logic                            accept;
    logic [pcmfc_pkg::CNT_W-1:0]     n_eff;
    pcmfc_pkg::div_ctl_t             ctl;
    logic [31:0]                     words [NL];
    logic signed [pcmfc_pkg::LANE_W-1:0] lane_val [NL];

    logic                            vld1_reg;
    logic                            fe1_reg;
    logic                            vld2_reg;
    logic                            fe2_reg;
    logic [pcmfc_pkg::PAIR_W-1:0]    pair_reg [2];
    logic [pcmfc_pkg::PAIR_W-1:0]    pair_next [2];
    logic                            vld3_reg;
    logic                            fe3_reg;
    logic [pcmfc_pkg::SUM_W-1:0]     sum_reg;
    logic [pcmfc_pkg::SUM_W-1:0]     sum_next;

    assign accept = start && !busy_reg;
    assign busy   = busy_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg  <= pcmfc_pkg::FMT_RESET;
            cnt_reg  <= pcmfc_pkg::CNT_RESET;
            busy_reg <= 1'b1;
        end
        else
        begin
            busy_reg <= 1'b0;
            if (cfg_we)
            begin
                case (pcmfc_pkg::cfg_reg_t'(cfg_index))
                    pcmfc_pkg::REG_SAMPLE_FORMAT: fmt_reg <= pcmfc_pkg::sample_fmt_t'(cfg_data[1:0]);
                    pcmfc_pkg::REG_CHANNEL_COUNT: cnt_reg <= cfg_data[pcmfc_pkg::CNT_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    always_comb
    begin
        if (cnt_reg == '0)
            n_eff = pcmfc_pkg::CNT_W'(1);
        else if (cnt_reg > pcmfc_pkg::CNT_W'(MAX_CHANNELS))
            n_eff = pcmfc_pkg::CNT_W'(MAX_CHANNELS);
        else
            n_eff = cnt_reg;
        ctl = pcmfc_pkg::div_ctl(n_eff);
    end

    assign words[0] = chan0_word;
    assign words[1] = chan1_word;
    assign words[2] = chan2_word;
    assign words[3] = chan3_word;
    assign words[4] = chan4_word;
    assign words[5] = chan5_word;
    assign words[6] = chan6_word;
    assign words[7] = chan7_word;

    for (genvar j = 0; j < NL; j++)
    begin : g_lane
        if (j < MAX_CHANNELS)
        begin : g_on
            pcmfc_lane u_lane (
                .clk    (clk),
                .load   (accept),
                .word   (words[j]),
                .fmt    (fmt_reg),
                .active (pcmfc_pkg::CNT_W'(j) < n_eff),
                .value  (lane_val[j])
            );
        end
        else
        begin : g_off
            assign lane_val[j] = '0;
        end
    end

    always_comb
    begin
        for (int h = 0; h < 2; h++)
        begin
            pair_next[h] = {{2{lane_val[4*h][60]}},   lane_val[4*h]}
                         + {{2{lane_val[4*h+1][60]}}, lane_val[4*h+1]}
                         + {{2{lane_val[4*h+2][60]}}, lane_val[4*h+2]}
                         + {{2{lane_val[4*h+3][60]}}, lane_val[4*h+3]};
        end
        sum_next = {pair_reg[0][62], pair_reg[0]} + {pair_reg[1][62], pair_reg[1]};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld1_reg <= 1'b0;
            vld2_reg <= 1'b0;
            vld3_reg <= 1'b0;
        end
        else
        begin
            vld1_reg <= accept;
            vld2_reg <= vld1_reg;
            vld3_reg <= vld2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
            fe1_reg <= frame_end_in;
        if (vld1_reg)
        begin
            fe2_reg     <= fe1_reg;
            pair_reg[0] <= pair_next[0];
            pair_reg[1] <= pair_next[1];
        end
        if (vld2_reg)
        begin
            fe3_reg <= fe2_reg;
            sum_reg <= sum_next;
        end
    end

    pcmfc_div u_div (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_vld        (vld3_reg),
        .in_sum        (sum_reg),
        .in_fe         (fe3_reg),
        .ctl           (ctl),
        .done          (done),
        .mono_sample   (mono_sample),
        .frame_end_out (frame_end_out)
    );

`ifndef SYNTHESIS
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy |-> ##6 done)
        else $error("accepted beat not delivered after six cycles");
    a_no_phantom: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 6))
        else $error("result without an accepted beat");
    a_busy_clear: assert property (@(posedge clk) disable iff (!rst_n)
        $past(rst_n) |-> !busy)
        else $error("busy high after reset release");
`endif

endmodule

// ----- sv/pcmfc_lane.sv -----
// One channel lane: decodes a raw word to signed fixed point (30 fraction bits), registered.
// Depends on pcmfc_pkg.
module pcmfc_lane (
    input  logic                                   clk,
    input  logic                                   load,
    input  logic [pcmfc_pkg::WORD_W-1:0]           word,
    input  pcmfc_pkg::sample_fmt_t                 fmt,
    input  logic                                   active,
    output logic signed [pcmfc_pkg::LANE_W-1:0]    value
);

    logic signed [pcmfc_pkg::LANE_W-1:0] value_reg;
    logic signed [pcmfc_pkg::LANE_W-1:0] value_next;

    logic        neg;
    logic [59:0] mag;
    logic [7:0]  a8;
    logic [2:0]  r8;
    logic [15:0] a16;
    logic [31:0] a32;
    logic [7:0]  e;
    logic [23:0] m24;
    logic [5:0]  sh_l;
    logic [7:0]  k;
    logic [23:0] t;
    logic [60:0] mag_ext;

    always_comb
    begin
        a8   = word[7] ? (word[7:0] - 8'd128) : (8'd128 - word[7:0]);
        r8   = 3'(a8 >= 8'd16) + 3'(a8 >= 8'd48) + 3'(a8 >= 8'd80) + 3'(a8 >= 8'd112);
        a16  = word[15] ? (16'd0 - word[15:0]) : word[15:0];
        a32  = word[31] ? (32'd0 - word) : word;
        e    = word[30:23];
        m24  = {1'b1, word[22:0]};
        sh_l = 6'(e - 8'd120);
        k    = 8'd120 - e;
        t    = m24 >> 5'(k - 8'd1);
        neg  = 1'b0;
        mag  = '0;
        case (fmt)
            pcmfc_pkg::FMT_U8:
            begin
                // 2^30/127 = 0x810204 + 4/127
                neg = ~word[7];
                mag = 60'({a8, 23'b0}) + 60'({a8, 16'b0}) + 60'({a8, 9'b0})
                    + 60'({a8, 2'b0}) + 60'(r8);
            end
            pcmfc_pkg::FMT_S16:
            begin
                // 2^30/32767 = 32769 + 1/32767
                neg = word[15];
                mag = 60'({a16, 15'b0}) + 60'(a16) + 60'(a16 >= 16'h4000);
            end
            pcmfc_pkg::FMT_S32:
            begin
                neg = word[31];
                mag = 60'((33'(a32) + 33'd1) >> 1) + 60'(a32 == 32'h8000_0000);
            end
            default:
            begin
                neg = word[31];
                if (e == 8'hFF)
                    mag = (word[22:0] != 23'd0) ? 60'd0 : pcmfc_pkg::CHAN_SAT;
                else if (e == 8'd0)
                    mag = '0;
                else if (e >= 8'd156)
                    mag = pcmfc_pkg::CHAN_SAT;
                else if (e >= 8'd120)
                    mag = 60'(m24) << sh_l;
                else if (k > 8'd25)
                    mag = '0;
                else
                    mag = 60'((25'(t) + 25'd1) >> 1);
            end
        endcase
        mag_ext    = {1'b0, mag};
        value_next = '0;
        if (active)
            value_next = $signed(neg ? (61'd0 - mag_ext) : mag_ext);
    end

    always_ff @(posedge clk)
    begin
        if (load)
            value_reg <= value_next;
    end

    assign value = value_reg;

endmodule

// ----- sv/pcmfc_div.sv -----
// Averaging divider: |sum| / n with round-half-away, Q1.30 saturation, three register stages.
// Depends on pcmfc_pkg; reciprocal multiply split in two 17-bit halves.
module pcmfc_div (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              in_vld,
    input  logic [pcmfc_pkg::SUM_W-1:0]       in_sum,
    input  logic                              in_fe,
    input  pcmfc_pkg::div_ctl_t               ctl,
    output logic                              done,
    output logic signed [31:0]                mono_sample,
    output logic                              frame_end_out
);

    localparam int PROD_W = pcmfc_pkg::SPLIT_W + pcmfc_pkg::RECIP_W;
    localparam int SUMP_W = PROD_W + pcmfc_pkg::SPLIT_W + 1;

    // stage 4
    logic        vld4_reg;
    logic        neg4_reg;
    logic        sat4_reg;
    logic        fe4_reg;
    logic [2:0]  odd4_reg;
    logic [33:0] p4_reg;
    // stage 5
    logic              vld5_reg;
    logic              neg5_reg;
    logic              sat5_reg;
    logic              fe5_reg;
    logic              one5_reg;
    logic [30:0]       byp5_reg;
    logic [PROD_W-1:0] phi5_reg;
    logic [PROD_W-1:0] plo5_reg;
    // stage 6
    logic        done_reg;
    logic        fe6_reg;
    logic [31:0] mono_reg;

    logic [62:0] mag;
    logic        big;
    logic [35:0] nval;
    logic [34:0] pval;
    logic        sat4_next;
    logic [pcmfc_pkg::RECIP_W-1:0] rcp;
    logic [PROD_W-1:0] phi_next;
    logic [PROD_W-1:0] plo_next;
    logic [SUMP_W-1:0] prod_sum;
    logic [30:0] q;
    logic [31:0] mono_next;

    always_comb
    begin
        mag       = in_sum[63] ? 63'(64'd0 - in_sum) : in_sum[62:0];
        big       = |mag[62:34];
        nval      = {1'b0, mag[33:0], 1'b0} + 36'(ctl.cnt);
        pval      = 35'(nval >> ctl.shift);
        sat4_next = big | (pval >= {1'b0, ctl.odd, 31'b0});
    end

    always_comb
    begin
        rcp      = pcmfc_pkg::recip(odd4_reg);
        phi_next = PROD_W'(p4_reg[33:17]) * PROD_W'(rcp);
        plo_next = PROD_W'(p4_reg[16:0]) * PROD_W'(rcp);
    end

    always_comb
    begin
        prod_sum = SUMP_W'({phi5_reg, 17'b0}) + SUMP_W'(plo5_reg);
        q        = one5_reg ? byp5_reg : prod_sum[pcmfc_pkg::RECIP_SHIFT +: 31];
        if (sat5_reg)
            mono_next = neg5_reg ? 32'h8000_0000 : 32'h7FFF_FFFF;
        else
            mono_next = neg5_reg ? (32'd0 - {1'b0, q}) : {1'b0, q};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld4_reg <= 1'b0;
            vld5_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld4_reg <= in_vld;
            vld5_reg <= vld4_reg;
            done_reg <= vld5_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_vld)
        begin
            neg4_reg <= in_sum[63];
            sat4_reg <= sat4_next;
            fe4_reg  <= in_fe;
            odd4_reg <= ctl.odd;
            p4_reg   <= pval[33:0];
        end
        if (vld4_reg)
        begin
            neg5_reg <= neg4_reg;
            sat5_reg <= sat4_reg;
            fe5_reg  <= fe4_reg;
            one5_reg <= (odd4_reg == 3'd1);
            byp5_reg <= p4_reg[30:0];
            phi5_reg <= phi_next;
            plo5_reg <= plo_next;
        end
        if (vld5_reg)
        begin
            fe6_reg  <= fe5_reg;
            mono_reg <= mono_next;
        end
    end

    assign done          = done_reg;
    assign mono_sample   = $signed(mono_reg);
    assign frame_end_out = fe6_reg;

`ifndef SYNTHESIS
    a_quot_fits: assert property (@(posedge clk) disable iff (!rst_n)
        vld5_reg && !sat5_reg && !one5_reg |-> prod_sum[SUMP_W-1:68] == '0)
        else $error("reciprocal quotient exceeds 31 bits");
    a_pos_sign: assert property (@(posedge clk) disable iff (!rst_n)
        vld5_reg && !neg5_reg |=> !mono_sample[31])
        else $error("non-negative sum gave negative average");
    a_sat_sticky: assert property (@(posedge clk) disable iff (!rst_n)
        in_vld && (in_sum[63:62] == 2'b01) |=> sat4_reg)
        else $error("huge positive sum not flagged as saturating");
`endif

endmodule

// ----- sim/pcm_downmix_checker.sv -----
// Checker for pcm_format_convert_downmix_mono: tracks the format and count registers,
// predicts the mono Q1.30 average for each accepted frame and compares every done beat.
// Depends on pcmfc_pkg.
module pcm_downmix_checker
    import pcmfc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data,
    input  logic                  start,
    input  logic                  busy,
    input  logic [31:0]           chan0_word,
    input  logic [31:0]           chan1_word,
    input  logic [31:0]           chan2_word,
    input  logic [31:0]           chan3_word,
    input  logic [31:0]           chan4_word,
    input  logic [31:0]           chan5_word,
    input  logic [31:0]           chan6_word,
    input  logic [31:0]           chan7_word,
    input  logic                  frame_end_in,
    input  logic                  done,
    input  logic signed [31:0]    mono_sample,
    input  logic                  frame_end_out,
    output int                    mismatches,
    output int                    outstanding
);

    localparam longint LANE_LIMIT = longint'(1) << 59;

    typedef struct {
        logic signed [31:0] sample;
        logic               frame_end;
    } mono_beat_t;

    sample_fmt_t      fmt_reg = FMT_RESET;
    logic [CNT_W-1:0] cnt_reg = CNT_RESET;
    logic [7:0][31:0] lanes;
    mono_beat_t       mono_due[$];

    assign lanes = {chan7_word, chan6_word, chan5_word, chan4_word,
                    chan3_word, chan2_word, chan1_word, chan0_word};

    function automatic longint lane_to_q30(sample_fmt_t fmt, logic [31:0] w);
        longint           x;
        longint unsigned  d;
        longint unsigned  mag;
        longint unsigned  m;
        int               sh;
        bit               neg;
        x = 0;
        d = 1;
        case (fmt)
            FMT_U8: begin
                x = longint'({24'd0, w[7:0]}) - 128;
                d = 127;
            end
            FMT_S16: begin
                x = longint'($signed(w[15:0]));
                d = 32767;
            end
            FMT_S32: begin
                x = longint'($signed(w));
                d = 2147483647;
            end
            default: begin
                neg = w[31];
                if (w[30:23] == 8'hFF) begin
                    if (w[22:0] != 23'd0)
                        return 0;
                    mag = LANE_LIMIT;
                end
                else if (w[30:23] == 8'h00) begin
                    return 0;
                end
                else begin
                    m  = {40'd0, 1'b1, w[22:0]};
                    sh = int'(w[30:23]) - 120;
                    if (sh >= 36)
                        mag = LANE_LIMIT;
                    else if (sh >= 0)
                        mag = m << sh;
                    else if (-sh > 25)
                        return 0;
                    else
                        mag = (m + (64'd1 << (-sh - 1))) >> (-sh);
                    if (mag > LANE_LIMIT)
                        mag = LANE_LIMIT;
                end
                return neg ? -longint'(mag) : longint'(mag);
            end
        endcase
        neg = x < 0;
        mag = neg ? -x : x;
        mag = ((mag << 30) * 2 + d) / (2 * d);
        return neg ? -longint'(mag) : longint'(mag);
    endfunction

    function automatic logic signed [31:0] expected_mono(sample_fmt_t fmt,
                                                        logic [CNT_W-1:0] cnt,
                                                        logic [7:0][31:0] w);
        longint unsigned n;
        longint unsigned mag;
        longint          sum;
        bit              neg;
        n = cnt;
        if (n == 0)
            n = 1;
        if (n > NUM_LANES)
            n = NUM_LANES;
        sum = 0;
        for (int j = 0; j < n; j++)
            sum += lane_to_q30(fmt, w[j]);
        neg = sum < 0;
        mag = neg ? -sum : sum;
        mag = (2 * mag + n) / (2 * n);
        if (neg)
            return (mag >= 64'h8000_0000) ? 32'sh8000_0000 : 32'(-longint'(mag));
        return (mag > 64'h7FFF_FFFF) ? 32'sh7FFF_FFFF : 32'(mag);
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        mono_beat_t due;
        mono_beat_t fresh;
        int         bad;
        if (!rst_n)
        begin
            fmt_reg     <= FMT_RESET;
            cnt_reg     <= CNT_RESET;
            mono_due.delete();
            mismatches  <= 0;
            outstanding <= 0;
        end
        else
        begin
            bad = 0;
            if (done)
            begin
                if (mono_due.size() == 0)
                begin
                    $display("%0t: unexpected beat, expected none, actual mono_sample %h frame_end %b",
                             $time, mono_sample, frame_end_out);
                    bad++;
                end
                else
                begin
                    due = mono_due.pop_front();
                    if (mono_sample !== due.sample)
                    begin
                        $display("%0t: mono_sample expected %h actual %h",
                                 $time, due.sample, mono_sample);
                        bad++;
                    end
                    if (frame_end_out !== due.frame_end)
                    begin
                        $display("%0t: frame_end_out expected %b actual %b",
                                 $time, due.frame_end, frame_end_out);
                        bad++;
                    end
                end
            end
            if (start && !busy)
            begin
                fresh.sample    = expected_mono(fmt_reg, cnt_reg, lanes);
                fresh.frame_end = frame_end_in;
                mono_due = {mono_due, fresh};
            end
            if (cfg_we)
            begin
                if (cfg_index == REG_SAMPLE_FORMAT)
                    fmt_reg <= sample_fmt_t'(cfg_data[1:0]);
                else
                    cnt_reg <= cfg_data;
            end
            mismatches  <= mismatches + bad;
            outstanding <= mono_due.size();
        end
    end

endmodule

// ----- sim/pcm_format_convert_downmix_mono_test.sv -----
// Testbench top for pcm_format_convert_downmix_mono: directed corner frames, then random
// frames over many format/count settings and sender idle rates; verdict from the checker.
// Depends on pcmfc_pkg, the block's RTL and pcm_downmix_checker.
module pcm_format_convert_downmix_mono_test;

    import pcmfc_pkg::*;

    localparam int PHASES          = 14;
    localparam int BEATS_PER_PHASE = 138;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    logic                  start;
    logic                  busy;
    logic [7:0][31:0]      chan_word;
    logic                  frame_end_in;
    logic                  done;
    logic signed [31:0]    mono_sample;
    logic                  frame_end_out;
    int                    mismatches;
    int                    outstanding;
    int                    idle_pct;

    pcm_format_convert_downmix_mono i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .chan0_word    (chan_word[0]),
        .chan1_word    (chan_word[1]),
        .chan2_word    (chan_word[2]),
        .chan3_word    (chan_word[3]),
        .chan4_word    (chan_word[4]),
        .chan5_word    (chan_word[5]),
        .chan6_word    (chan_word[6]),
        .chan7_word    (chan_word[7]),
        .frame_end_in  (frame_end_in),
        .done          (done),
        .mono_sample   (mono_sample),
        .frame_end_out (frame_end_out)
    );

    pcm_downmix_checker i_checker (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .start         (start),
        .busy          (busy),
        .chan0_word    (chan_word[0]),
        .chan1_word    (chan_word[1]),
        .chan2_word    (chan_word[2]),
        .chan3_word    (chan_word[3]),
        .chan4_word    (chan_word[4]),
        .chan5_word    (chan_word[5]),
        .chan6_word    (chan_word[6]),
        .chan7_word    (chan_word[7]),
        .frame_end_in  (frame_end_in),
        .done          (done),
        .mono_sample   (mono_sample),
        .frame_end_out (frame_end_out),
        .mismatches    (mismatches),
        .outstanding   (outstanding)
    );

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    initial
    begin
        #1000000;
        $display("end of test: mismatches");
        $finish;
    end

    // holds start high until the beat is taken
    task automatic send_frame(input logic [7:0][31:0] lanes, input logic frame_end);
        start        <= 1'b1;
        chan_word    <= lanes;
        frame_end_in <= frame_end;
        do
            @(posedge clk);
        while (busy);
        if ($urandom_range(99) < idle_pct)
        begin
            start <= 1'b0;
            do
                @(posedge clk);
            while ($urandom_range(99) < idle_pct);
        end
    endtask

    task automatic drain;
        start <= 1'b0;
        @(posedge clk);
        while (outstanding != 0)
            @(posedge clk);
    endtask

    task automatic set_format_and_count(input sample_fmt_t fmt, input logic [3:0] count);
        drain();
        cfg_we    <= 1'b1;
        cfg_index <= REG_SAMPLE_FORMAT;
        cfg_data  <= {2'($urandom_range(3)), fmt};
        @(posedge clk);
        cfg_index <= REG_CHANNEL_COUNT;
        cfg_data  <= count;
        @(posedge clk);
        cfg_we    <= 1'b0;
    endtask

    function automatic logic [31:0] random_word(sample_fmt_t fmt);
        logic [31:0] w;
        int          pick;
        int          k;
        w    = $urandom;
        pick = $urandom_range(9);
        k    = $urandom_range(3);
        if (pick == 0)
        begin
            case (fmt)
                FMT_U8:  w[7:0]  = (k == 0) ? 8'h00 : (k == 1) ? 8'hFF : (k == 2) ? 8'h80 : 8'h7F;
                FMT_S16: w[15:0] = (k == 0) ? 16'h7FFF : (k == 1) ? 16'h8000 :
                                   (k == 2) ? 16'h0000 : 16'hFFFF;
                FMT_S32: w = (k == 0) ? 32'h7FFF_FFFF : (k == 1) ? 32'h8000_0000 :
                             (k == 2) ? 32'h0000_0000 : 32'hFFFF_FFFF;
                default:
                begin
                    case (k)
                        0: w[30:0] = {8'hFF, 23'd0};
                        1: w[30:23] = 8'hFF;
                        2: w[30:23] = 8'h00;
                        default: w[30:23] = 8'hFE;
                    endcase
                end
            endcase
        end
        else if (fmt == FMT_F32 && pick < 7)
        begin
            w[30:23] = 8'($urandom_range(160, 90));
        end
        return w;
    endfunction

    initial
    begin
        sample_fmt_t      fmt;
        logic [3:0]       count;
        logic [7:0][31:0] lanes;
        sample_fmt_t      fmt_plan[8];
        logic [3:0]       count_plan[8];
        int               pct_plan[4];

        fmt_plan   = '{FMT_U8, FMT_S16, FMT_S32, FMT_F32, FMT_F32, FMT_U8, FMT_S16, FMT_S32};
        count_plan = '{4'd1, 4'd8, 4'd0, 4'd15, 4'd1, 4'd8, 4'd3, 4'd5};
        pct_plan   = '{0, 64, 25, 0};
        idle_pct   = 0;

        rst_n        <= 1'b0;
        cfg_we       <= 1'b0;
        cfg_index    <= REG_SAMPLE_FORMAT;
        cfg_data     <= '0;
        start        <= 1'b0;
        chan_word    <= '0;
        frame_end_in <= 1'b0;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;

        // reset setting: signed 16-bit, two channels; high bits of the words ignored
        send_frame({8{32'h0000_7FFF}}, 1'b0);
        send_frame({8{32'h0000_8000}}, 1'b1);
        send_frame({{6{32'h0}}, 32'h0000_8000, 32'hFFFF_7FFF}, 1'b0);
        send_frame({8{32'hFFFF_0000}}, 1'b1);

        set_format_and_count(FMT_U8, 4'd1);
        send_frame({{7{32'h0}}, 32'h0000_00FF}, 1'b0);
        send_frame({{7{32'hFFFF_FFFF}}, 32'h0000_0000}, 1'b1);
        send_frame({{7{32'h0}}, 32'h0000_0080}, 1'b0);
        send_frame({{7{32'h0}}, 32'hFFFF_FF7F}, 1'b0);

        set_format_and_count(FMT_S32, 4'd8);
        send_frame({8{32'h7FFF_FFFF}}, 1'b0);
        send_frame({8{32'h8000_0000}}, 1'b1);

        // float: infinities, NaN, denormal, tiny values, saturation at both ends
        set_format_and_count(FMT_F32, 4'd8);
        send_frame({8{32'h7F80_0000}}, 1'b0);
        send_frame({8{32'hFF80_0000}}, 1'b1);
        send_frame({{7{32'h3F80_0000}}, 32'h7FC0_0001}, 1'b0);
        send_frame({32'h3100_0000, 32'h3080_0000, 32'h2F80_0000, 32'h8000_0001,
                    32'h0000_0001, 32'h007F_FFFF, 32'h3000_0000, 32'hB080_0000}, 1'b0);
        send_frame({8{32'h4000_0000}}, 1'b0);
        send_frame({8{32'hC000_0000}}, 1'b1);
        send_frame({8{32'h7F7F_FFFF}}, 1'b0);

        // count zero works as one, count above eight as eight
        set_format_and_count(FMT_F32, 4'd0);
        send_frame({{7{32'h7F80_0000}}, 32'h3F00_0000}, 1'b0);
        set_format_and_count(FMT_S16, 4'd15);
        send_frame({32'h0000_7FFF, 32'h0000_8000, 32'h0000_1234, 32'h0000_FFFF,
                    32'h0000_0001, 32'h0000_7FFF, 32'h0000_7FFF, 32'h0000_7FFF}, 1'b1);

        for (int p = 0; p < PHASES; p++)
        begin
            if (p < 8)
            begin
                fmt   = fmt_plan[p];
                count = count_plan[p];
            end
            else
            begin
                fmt   = sample_fmt_t'($urandom_range(3));
                count = ($urandom_range(3) == 0) ? 4'($urandom_range(15))
                                                 : 4'($urandom_range(8, 1));
            end
            set_format_and_count(fmt, count);
            idle_pct = pct_plan[p % 4];
            for (int i = 0; i < BEATS_PER_PHASE; i++)
            begin
                for (int j = 0; j < 8; j++)
                    lanes[j] = random_word(fmt);
                send_frame(lanes, 1'($urandom_range(1)));
            end
        end

        drain();
        repeat (12) @(posedge clk);
        if (mismatches == 0 && outstanding == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end

endmodule
